// ===== design/bfws_pkg.sv =====
// Shared constants and result type for the box filter window sum block.
`timescale 1ns / 1ps

package bfws_pkg;

    // Configuration port
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_RADIUS_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 8'd2;

    localparam int WIDTH_RST  = 1024;
    localparam int HEIGHT_RST = 1024;
    localparam int RADIUS_RST = 1;

    // Item fields
    localparam logic OP_FLUSH = 1'b1;
    localparam int   SAMPLE_W = 16;
    localparam int   SUM_W    = 26;
    localparam int   X_W      = 10;
    localparam int   Y_W      = 16;

    // Result queue
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic signed [SUM_W-1:0] box_sum;
        logic [X_W-1:0]          x;
        logic [Y_W-1:0]          y;
        logic                    last_burst;
        logic                    last_frame;
    } result_t;

endpackage

// ===== design/box_filter_window_sum_top.sv =====
// Streaming 2-D box filter: zero-padded (2r+1) x (2r+1) window sums in raster order.
`timescale 1ns / 1ps

// Channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------------
// in       | in_valid / in_ready    | op, sample
// out      | out_valid / out_ready  | box_sum, out_x, out_y, last_of_burst, last_of_frame
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Flow: one item per cycle while in_ready is high. The last item of each row is
//   followed by r internal zero-sample steps (in_ready low) that close the right-hand
//   columns; the column-sum memory handles one column per step, and such steps are held
//   while the result queue lacks room or a register write is in progress.
// Reset: asynchronous, active low; no clearing pass. Column sums of the first row of
//   a frame are taken as zero, and the row-sum store is only read once written.
// Stalls: a 4-entry result queue decouples out_ready from in_ready; input stalls only
//   when the queue cannot absorb the item in flight plus the next one, in a cycle
//   that carries a register write, and during the zero-sample steps after a row.
// Mapped register writes restart the frame at (0, 0); cfg_ready is always high.

module box_filter_window_sum_top
    import bfws_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 15
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       op,
    input  logic signed [SAMPLE_W-1:0] sample,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SUM_W-1:0]    box_sum,
    output logic [X_W-1:0]             out_x,
    output logic [Y_W-1:0]             out_y,
    output logic                       last_of_burst,
    output logic                       last_of_frame,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    // Derived sizes
    localparam int WIN        = 2 * MAX_RADIUS + 1;
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int POS_W      = $clog2(MAX_WIDTH + MAX_RADIUS);
    localparam int ROW_W      = $clog2((1 << CFG_HEIGHT_W) + MAX_RADIUS);
    localparam int SLOT_W     = $clog2(WIN);
    localparam int RS_W       = SAMPLE_W + $clog2(WIN);
    localparam int CS_W       = RS_W + $clog2(WIN);
    localparam int RMEM_DEPTH = WIN * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(RMEM_DEPTH);
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int W_RST      = (MAX_WIDTH < WIDTH_RST) ? MAX_WIDTH : WIDTH_RST;
    localparam int R_RST      = (MAX_RADIUS < RADIUS_RST) ? MAX_RADIUS : RADIUS_RST;

    // ------------------------------------------------------------------
    // Configuration (stored already clamped to the usable range)
    // ------------------------------------------------------------------
    logic [WCNT_W-1:0]       width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic                    cfg_fire;
    logic                    cfg_hit;
    logic [CFG_WIDTH_W-1:0]  cfg_w_val;
    logic [CFG_RADIUS_W-1:0] cfg_r_val;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_w_val = cfg_data[CFG_WIDTH_W-1:0];
    assign cfg_r_val = cfg_data[CFG_RADIUS_W-1:0];
    assign cfg_hit   = cfg_fire && (cfg_index == REG_FRAME_WIDTH
                                    || cfg_index == REG_FRAME_HEIGHT
                                    || cfg_index == REG_WINDOW_RADIUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WCNT_W'(W_RST);
            height_reg <= CFG_HEIGHT_W'(HEIGHT_RST);
            radius_reg <= RAD_W'(R_RST);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (cfg_w_val == '0)
                        width_reg <= WCNT_W'(1);
                    else if (32'(cfg_w_val) > 32'(MAX_WIDTH))
                        width_reg <= WCNT_W'(MAX_WIDTH);
                    else
                        width_reg <= WCNT_W'(cfg_w_val);
                end
                REG_FRAME_HEIGHT:
                begin
                    if (cfg_data[CFG_HEIGHT_W-1:0] == '0)
                        height_reg <= CFG_HEIGHT_W'(1);
                    else
                        height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                end
                REG_WINDOW_RADIUS:
                begin
                    if (32'(cfg_r_val) > 32'(MAX_RADIUS))
                        radius_reg <= RAD_W'(MAX_RADIUS);
                    else
                        radius_reg <= RAD_W'(cfg_r_val);
                end
                default:
                begin
                    // index beyond the register list: ignored
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: position counters, sample window, running row sum.
    // Positions W..W+r-1 are internal zero-sample steps after each row.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [ADDR_W-1:0]         base_reg, base_next;
    logic                      tail_reg, tail_next;
    logic signed [SAMPLE_W-1:0] win_reg [WIN];
    logic signed [RS_W-1:0]    run_reg, run_next;

    logic [POS_W-1:0]          last_x;
    logic [POS_W-1:0]          row_end_pos;
    logic                      at_last_x;
    logic                      at_row_end;
    logic                      pos_ge_r;
    logic                      row_ge_r;
    logic                      row_ge_span;
    logic                      in_frame;
    logic [ROW_W-1:0]          h_plus_r;
    logic                      frame_end;
    logic                      slot_last;
    logic [SLOT_W-1:0]         tap_idx;
    logic signed [SAMPLE_W-1:0] s_new;
    logic [COL_W-1:0]          col;
    logic [ADDR_W-1:0]         rmem_addr;
    logic                      room;
    logic                      in_fire;
    logic                      step;
    logic                      ev_fire;

    assign last_x      = POS_W'(width_reg) - POS_W'(1);
    assign row_end_pos = last_x + POS_W'(radius_reg);
    assign at_last_x   = (pos_reg == last_x);
    assign at_row_end  = (pos_reg == row_end_pos);
    assign pos_ge_r    = (pos_reg >= POS_W'(radius_reg));
    assign row_ge_r    = (row_reg >= ROW_W'(radius_reg));
    assign row_ge_span = (row_reg >= ROW_W'({radius_reg, 1'b1}));
    assign in_frame    = (row_reg < ROW_W'(height_reg));
    assign h_plus_r    = ROW_W'(height_reg) + ROW_W'(radius_reg);
    assign frame_end   = ((row_reg + ROW_W'(1)) >= h_plus_r);
    assign tap_idx     = SLOT_W'({radius_reg, 1'b0});
    assign slot_last   = (slot_reg == tap_idx);
    assign col         = COL_W'(pos_reg - POS_W'(radius_reg));
    assign rmem_addr   = base_reg + ADDR_W'(col);

    // a register write takes the cycle: no item is accepted alongside it
    assign in_ready = !tail_reg && room && !cfg_fire;
    assign in_fire  = in_valid && in_ready;
    assign step     = !cfg_fire && (in_fire || (tail_reg && room));
    assign ev_fire  = step && pos_ge_r;

    // flush items, rows below the frame and tail steps all feed zero
    always_comb
    begin
        if (!tail_reg && op != OP_FLUSH && in_frame)
            s_new = sample;
        else
            s_new = '0;
    end

    always_comb
    begin
        if (pos_reg == '0)
            run_next = RS_W'(s_new);
        else
            run_next = run_reg - RS_W'(win_reg[tap_idx]) + RS_W'(s_new);
    end

    always_comb
    begin
        pos_next  = pos_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        base_next = base_reg;
        tail_next = tail_reg;
        if (step)
        begin
            if (at_row_end)
            begin
                pos_next  = '0;
                tail_next = 1'b0;
                if (frame_end)
                begin
                    row_next  = '0;
                    slot_next = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    if (slot_last)
                    begin
                        slot_next = '0;
                        base_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                        base_next = base_reg + ADDR_W'(MAX_WIDTH);
                    end
                end
            end
            else
            begin
                pos_next  = pos_reg + POS_W'(1);
                tail_next = tail_reg || at_last_x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            base_reg <= '0;
            tail_reg <= 1'b0;
            run_reg  <= '0;
            for (int i = 0; i < WIN; i++)
                win_reg[i] <= '0;
        end
        else if (cfg_hit)
        begin
            pos_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            base_reg <= '0;
            tail_reg <= 1'b0;
            run_reg  <= '0;
            for (int i = 0; i < WIN; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            base_reg <= base_next;
            tail_reg <= tail_next;
            if (step)
            begin
                run_reg    <= run_next;
                win_reg[0] <= s_new;
                // row start: older taps read as zero
                for (int i = 1; i < WIN; i++)
                    win_reg[i] <= (pos_reg == '0) ? '0 : win_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Row-sum line store: read the leaving row sum and write the new one
    // at the same address in the same cycle (read-first).
    // ------------------------------------------------------------------
    logic signed [RS_W-1:0] row_mem [RMEM_DEPTH];
    logic signed [RS_W-1:0] leave_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ev_fire)
        begin
            leave_rd_reg       <= row_mem[rmem_addr];
            row_mem[rmem_addr] <= run_next;
        end
    end

    // ------------------------------------------------------------------
    // Column event stage: column-sum read-modify-write
    // ------------------------------------------------------------------
    logic                    e1_valid_reg;
    logic [COL_W-1:0]        e1_col_reg;
    logic signed [RS_W-1:0]  e1_sum_reg;
    logic                    e1_first_reg;
    logic                    e1_leave_en_reg;
    logic                    e1_emit_reg;
    logic [Y_W-1:0]          e1_y_reg;
    logic                    e1_lb_reg;
    logic                    e1_lf_reg;

    logic signed [CS_W-1:0]  col_mem [MAX_WIDTH];
    logic signed [CS_W-1:0]  colsum_rd_reg;
    logic                    fwd_hit_reg;
    logic signed [CS_W-1:0]  fwd_val_reg;
    logic signed [CS_W-1:0]  old_sum;
    logic signed [CS_W-1:0]  leave_sum;
    logic signed [CS_W-1:0]  colsum_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            e1_valid_reg <= ev_fire;
            // back-to-back events on one column: memory read misses the write
            fwd_hit_reg  <= ev_fire && e1_valid_reg && (col == e1_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_val_reg <= colsum_new;
        if (ev_fire)
        begin
            e1_col_reg      <= col;
            e1_sum_reg      <= run_next;
            e1_first_reg    <= (row_reg == '0);
            e1_leave_en_reg <= row_ge_span;
            e1_emit_reg     <= row_ge_r;
            e1_y_reg        <= Y_W'(row_reg - ROW_W'(radius_reg));
            e1_lb_reg       <= (pos_reg < last_x) || at_row_end;
            e1_lf_reg       <= at_row_end && ((row_reg + ROW_W'(1)) == h_plus_r);
        end
    end

    always_comb
    begin
        if (e1_first_reg)
            old_sum = '0;
        else if (fwd_hit_reg)
            old_sum = fwd_val_reg;
        else
            old_sum = colsum_rd_reg;
        if (e1_leave_en_reg)
            leave_sum = CS_W'(leave_rd_reg);
        else
            leave_sum = '0;
        colsum_new = old_sum + CS_W'(e1_sum_reg) - leave_sum;
    end

    always_ff @(posedge clk)
    begin
        if (ev_fire)
            colsum_rd_reg <= col_mem[col];
        if (e1_valid_reg)
            col_mem[e1_col_reg] <= colsum_new;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    result_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      wr_ptr_reg;
    logic [FIFO_AW-1:0]      rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   fifo_cnt_reg;
    logic                    fifo_push;
    logic                    fifo_pop;
    result_t                 push_item;
    result_t                 head;

    assign fifo_push = e1_valid_reg && e1_emit_reg;
    assign fifo_pop  = out_valid && out_ready;
    // space for the event in flight plus the one this cycle may start
    assign room = (({1'b0, fifo_cnt_reg} + (FIFO_CNT_W+1)'(e1_valid_reg))
                   < (FIFO_CNT_W+1)'(FIFO_DEPTH));

    always_comb
    begin
        push_item.box_sum    = SUM_W'(colsum_new);
        push_item.x          = X_W'(e1_col_reg);
        push_item.y          = e1_y_reg;
        push_item.last_burst = e1_lb_reg;
        push_item.last_frame = e1_lf_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
            fifo_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (fifo_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (fifo_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (fifo_push && !fifo_pop)
                fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(1);
            else if (fifo_pop && !fifo_push)
                fifo_cnt_reg <= fifo_cnt_reg - FIFO_CNT_W'(1);
        end
    end

    assign head          = fifo_mem[rd_ptr_reg];
    assign out_valid     = (fifo_cnt_reg != '0);
    assign box_sum       = head.box_sum;
    assign out_x         = head.x;
    assign out_y         = head.y;
    assign last_of_burst = head.last_burst;
    assign last_of_frame = head.last_frame;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_push && fifo_cnt_reg == FIFO_CNT_W'(FIFO_DEPTH)) |-> fifo_pop)
        else $error("result queue overflow");

    a_tail_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && at_last_x && radius_reg != '0 && !cfg_fire) |=> tail_reg)
        else $error("row end not followed by tail steps");

    a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> (e1_valid_reg && $past(e1_valid_reg)
                         && e1_col_reg == $past(e1_col_reg)))
        else $error("column forward without matching column");

    a_frame_end_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_frame) |-> last_of_burst)
        else $error("frame end result not last of its burst");

endmodule

// ===== bench/bfws_checker.sv =====
// Checker for the box filter: predicts window sums from accepted items and compares results.
`timescale 1ns / 1ps

module bfws_checker
    import bfws_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 15
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       op,
    input  logic signed [SAMPLE_W-1:0] sample,

    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SUM_W-1:0]    box_sum,
    input  logic [X_W-1:0]             out_x,
    input  logic [Y_W-1:0]             out_y,
    input  logic                       last_of_burst,
    input  logic                       last_of_frame,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    output int                         mismatches,
    output int                         outstanding,
    output int                         compared
);

    localparam int SPAN_MAX = 2 * MAX_RADIUS + 1;

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_RADIUS_W-1:0] radius_reg;

    int          line_sums [SPAN_MAX * MAX_WIDTH];  // row sums of the last 2r+1 rows
    int          column_sums [MAX_WIDTH];
    int          taps [SPAN_MAX];                   // last 2r+1 samples of the row
    int          row_acc;
    int unsigned col_pos;
    int unsigned row_pos;
    result_t     awaited_sums [$];
    int          err_count;
    int          match_count;

    function automatic void restart_frame();
        foreach (column_sums[i]) column_sums[i] = 0;
        foreach (taps[i]) taps[i] = 0;
        row_acc = 0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Row sum of column col is complete for the current row.
    function automatic void close_column(input int unsigned col, input int unsigned r,
                                         input int unsigned w, input int unsigned h);
        int unsigned span;
        int unsigned slot;
        int unsigned yy;
        int          leaving;
        int          csum;
        result_t     res;
        span    = 2 * r + 1;
        slot    = (row_pos % span) * MAX_WIDTH + col;
        leaving = (row_pos >= span) ? line_sums[slot] : 0;
        line_sums[slot] = row_acc;
        column_sums[col] += row_acc - leaving;
        if (row_pos >= r)
        begin
            yy             = row_pos - r;
            csum           = column_sums[col];
            res.box_sum    = csum[SUM_W-1:0];
            res.x          = col[X_W-1:0];
            res.y          = yy[Y_W-1:0];
            res.last_burst = 1'b0;
            res.last_frame = (col == w - 1 && yy == h - 1);
            awaited_sums.push_back(res);
        end
    endfunction

    function automatic void advance_window(input logic op_i,
                                           input logic signed [SAMPLE_W-1:0] smp);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned x;
        int unsigned k;
        int          i;
        int          s;
        int          queued;
        result_t     tail;
        w = (width_reg == 0) ? 1 :
            (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h = (height_reg == 0) ? 1 : int'(height_reg);
        r = (int'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
        x = col_pos;
        s = (op_i != OP_FLUSH && row_pos < h) ? int'(smp) : 0;
        queued = awaited_sums.size();

        if (x == 0)
        begin
            foreach (taps[j]) taps[j] = 0;
            row_acc = 0;
        end
        row_acc -= taps[2 * r];
        for (i = 2 * r; i > 0; i--) taps[i] = taps[i - 1];
        taps[0] = s;
        row_acc += s;

        if (x >= r) close_column(x - r, r, w, h);
        // row end: shift zeros in to close the right-hand columns
        if (x == w - 1)
        begin
            for (k = 1; k <= r; k++)
            begin
                row_acc -= taps[2 * r + 1 - k];
                if (w - 1 + k >= r) close_column(w - 1 + k - r, r, w, h);
            end
        end

        if (awaited_sums.size() > queued)
        begin
            tail = awaited_sums.pop_back();
            tail.last_burst = 1'b1;
            awaited_sums.push_back(tail);
        end

        if (x == w - 1)
        begin
            if (row_pos >= h + r - 1)
                restart_frame();
            else
            begin
                col_pos = 0;
                row_pos++;
            end
        end
        else
            col_pos = x + 1;
    endfunction

    function automatic void apply_write();
        case (cfg_index)
            REG_FRAME_WIDTH:
            begin
                width_reg = cfg_data[CFG_WIDTH_W-1:0];
                restart_frame();
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg = cfg_data[CFG_HEIGHT_W-1:0];
                restart_frame();
            end
            REG_WINDOW_RADIUS:
            begin
                radius_reg = cfg_data[CFG_RADIUS_W-1:0];
                restart_frame();
            end
            default: ;  // unmapped index: no effect
        endcase
    endfunction

    function automatic void check_result();
        result_t want;
        if (awaited_sums.size() == 0)
        begin
            $error("result at x=%0d y=%0d arrived with no item waiting", out_x, out_y);
            err_count++;
            return;
        end
        want = awaited_sums.pop_front();
        match_count++;
        if (box_sum !== want.box_sum)
        begin
            $error("box_sum: expected %0d, actual %0d", want.box_sum, box_sum);
            err_count++;
        end
        if (out_x !== want.x)
        begin
            $error("out_x: expected %0d, actual %0d", want.x, out_x);
            err_count++;
        end
        if (out_y !== want.y)
        begin
            $error("out_y: expected %0d, actual %0d", want.y, out_y);
            err_count++;
        end
        if (last_of_burst !== want.last_burst)
        begin
            $error("last_of_burst: expected %0b, actual %0b", want.last_burst, last_of_burst);
            err_count++;
        end
        if (last_of_frame !== want.last_frame)
        begin
            $error("last_of_frame: expected %0b, actual %0b", want.last_frame, last_of_frame);
            err_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   = CFG_WIDTH_W'(WIDTH_RST);
            height_reg  = CFG_HEIGHT_W'(HEIGHT_RST);
            radius_reg  = CFG_RADIUS_W'(RADIUS_RST);
            restart_frame();
            awaited_sums.delete();
            err_count   = 0;
            match_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
            compared    <= 0;
        end
        else
        begin
            // results first: an item taken at this edge cannot have produced one yet
            if (out_valid && out_ready) check_result();
            if (cfg_valid && cfg_ready) apply_write();
            if (in_valid && in_ready) advance_window(op, sample);
            mismatches  <= err_count;
            outstanding <= awaited_sums.size();
            compared    <= match_count;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the box filter window sum block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
    import bfws_pkg::*;

    localparam int     CLK_HALF_NS      = 10;
    localparam int     RESET_CYCLES     = 7;
    localparam int     MAX_WIDTH        = 1024;
    localparam int     MAX_RADIUS       = 15;
    localparam int     RANDOM_ITEMS     = 450;
    // idle time before a register write: covers the r zero steps after a row end
    // plus the result pipeline, for items that leave no result behind
    localparam int     SETTLE_CYCLES    = 2 * MAX_RADIUS + 10;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam longint TIMEOUT_NS       = 64'd50_000_000;

    localparam logic                 OP_PIXEL     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MIN   = 16'h8000;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX   = 16'h7FFF;

    logic                       clk = 1'b0;
    logic                       rst_n;

    logic                       in_valid;
    logic                       in_ready;
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;

    logic                       out_valid;
    logic                       out_ready;
    logic signed [SUM_W-1:0]    box_sum;
    logic [X_W-1:0]             out_x;
    logic [Y_W-1:0]             out_y;
    logic                       last_of_burst;
    logic                       last_of_frame;

    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int mismatches;
    int outstanding;
    int compared;

    // Stimulus bookkeeping. cur_* hold the effective frame geometry so the
    // generator knows which items fall in frame rows and which in flush rows.
    int unsigned cur_w = WIDTH_RST;
    int unsigned cur_h = HEIGHT_RST;
    int unsigned cur_r = RADIUS_RST;
    int          burst_left    = 0;
    bit          no_gaps       = 1'b0;
    int          items_sent    = 0;
    int          configs_used  = 0;
    int          hold_requests = 0;

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    box_filter_window_sum_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .box_sum       (box_sum),
        .out_x         (out_x),
        .out_y         (out_y),
        .last_of_burst (last_of_burst),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bfws_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) sum_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .box_sum       (box_sum),
        .out_x         (out_x),
        .out_y         (out_y),
        .last_of_burst (last_of_burst),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .compared      (compared)
    );

    // Pixel values lean on the rails so window sums reach their extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_W'($urandom_range(0, 15));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Sometimes sets the register bits above the field, which must be dropped.
    function automatic logic [CFG_DATA_W-1:0] with_stray_bits(input int unsigned value,
                                                              input int used_bits);
        logic [CFG_DATA_W-1:0] keep_mask;
        keep_mask = CFG_DATA_W'((1 << used_bits) - 1);
        if ($urandom_range(0, 2) != 0)
            return CFG_DATA_W'(value);
        return (CFG_DATA_W'(value) & keep_mask) | (CFG_DATA_W'($urandom()) & ~keep_mask);
    endfunction

    // One register write; valid drops for a cycle afterwards so back-to-back
    // writes never lower and raise it in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all three registers; only called with the block idle.
    task automatic configure(input int unsigned w_raw, input int unsigned h_raw,
                             input int unsigned r_raw);
        write_reg(REG_FRAME_WIDTH, with_stray_bits(w_raw, CFG_WIDTH_W));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
        write_reg(REG_WINDOW_RADIUS, with_stray_bits(r_raw, CFG_RADIUS_W));
        cur_w = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
        cur_h = (h_raw == 0) ? 1 : h_raw;
        cur_r = (r_raw > MAX_RADIUS) ? MAX_RADIUS : r_raw;
        configs_used++;
    endtask

    // Offers one item. The sender runs in bursts; at a burst boundary it may
    // drop valid before the next item. Valid stays up across items inside a burst.
    task automatic offer(input logic op_v, input logic [SAMPLE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        op       <= op_v;
        sample   <= value;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Items first..first+count-1 of a frame in raster order. Frame rows carry
    // pixels, the trailing r rows carry flush items. The noisy form mixes in
    // flush items inside the frame and pixel items in the flush rows.
    task automatic send_items(input int unsigned first, input int unsigned count,
                              input bit noisy, input bit pinned,
                              input logic [SAMPLE_W-1:0] pinned_val);
        int unsigned k;
        logic        op_v;
        logic [SAMPLE_W-1:0] value;
        for (k = first; k < first + count; k++)
        begin
            if (k / cur_w < cur_h)
            begin
                op_v  = (noisy && $urandom_range(0, 5) == 0) ? OP_FLUSH : OP_PIXEL;
                value = pinned ? pinned_val : pick_sample();
            end
            else
            begin
                op_v  = (noisy && $urandom_range(0, 2) == 0) ? OP_PIXEL : OP_FLUSH;
                value = pick_sample();
            end
            offer(op_v, value);
        end
    endtask

    // Stop sending and wait until every predicted result is back, then let
    // the block run out its zero steps before anything else touches it.
    task automatic finish_phase();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: switches between always ready, random stalls and a fixed
    // one-in-three pattern. A hold request from the stimulus forces a long
    // stretch of backpressure, counted here.
    initial
    begin : receiver
        int holds_done;
        int mode;
        int mode_left;
        int tick;
        holds_done = 0;
        mode       = 0;
        mode_left  = 0;
        tick       = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= (tick % 3 == 0);
                default: out_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned r_raw;
        int unsigned full;
        int unsigned count;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_PIXEL;
        sample    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry (1024 wide, radius 1): the first row yields nothing,
        // so these rail values and a flush item inside the frame must stay quiet.
        offer(OP_PIXEL, SAMPLE_MIN);
        offer(OP_PIXEL, SAMPLE_MAX);
        offer(OP_FLUSH, 16'h1234);
        offer(OP_PIXEL, 16'hFFFF);
        finish_phase();

        // 1x1 frame, radius 0: every item is its own frame and its own sum.
        configure(1, 1, 0);
        offer(OP_PIXEL, SAMPLE_MIN);
        offer(OP_PIXEL, SAMPLE_MAX);
        offer(OP_PIXEL, 16'h0001);
        offer(OP_PIXEL, 16'hFFFF);
        offer(OP_FLUSH, 16'h5555);
        finish_phase();

        // Zero width and height act as 1; radius 15 needs 15 flush rows, whose
        // values (pixel or not) must be ignored.
        configure(0, 0, 15);
        offer(OP_PIXEL, SAMPLE_MAX);
        send_items(1, 15, 1'b1, 1'b0, '0);
        finish_phase();

        // Frame paused mid-row, a write to an unmapped index, then resumed:
        // the write must not restart the frame.
        configure(5, 4, 1);
        send_items(0, 12, 1'b0, 1'b0, '0);
        finish_phase();
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom()));
        send_items(12, 13, 1'b0, 1'b0, '0);
        finish_phase();

        // Oversized width clamps to 1024 and the tallest frame; radius 0 gives
        // a result per item. The receiver holds off at the start so the result
        // queue fills and the input has to stall.
        configure(2047, 65535, 0);
        hold_requests <= hold_requests + 1;
        send_items(0, MAX_WIDTH + 16, 1'b0, 1'b0, '0);
        finish_phase();

        // Full 31x31 window of the most negative pixel: reaches the lowest sum
        // and 16-result bursts at each row end.
        configure(31, 31, 15);
        send_items(0, 31 * 46, 1'b0, 1'b1, SAMPLE_MIN);
        finish_phase();

        // Random small frames, mostly complete and well formed; some are cut
        // short by the next register write, some carry misplaced ops.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            w_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            h_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            if (w_raw <= 3 && $urandom_range(0, 3) == 0)
                r_raw = $urandom_range(5, 15);
            else
                r_raw = $urandom_range(0, 4);
            configure(w_raw, h_raw, r_raw);
            full = cur_w * (cur_h + cur_r);
            if (full > 1 && $urandom_range(0, 4) == 0)
                count = $urandom_range(1, full - 1);
            else
                count = full;
            no_gaps = ($urandom_range(0, 4) == 0);
            send_items(0, count, $urandom_range(0, 3) == 0, 1'b0, '0);
            finish_phase();
            random_items += count;
        end

        $display("Run covered %0d items under %0d register settings, %0d results compared.",
                 items_sent, configs_used, compared);
        $display("Geometry ranged from 1x1 frames to clamped 1024-pixel rows, radius 0 to 15.");
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
